@@ rtl/core/sha256_pkg.sv @@
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_req_t;

  // command handed from the front part to the compression engine
  typedef struct packed {
    logic        final_blk;
  } blk_cmd_t;

  typedef enum logic [2:0] {
    EngIdle,
    EngRound,
    EngAdd,
    EngEmit
  } eng_state_e;

  localparam int unsigned NumRounds = 64;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [255:0] init_hash();
    return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endfunction

endpackage

@@ rtl/core/sha256_front.sv @@
// collects bytes into a block, pads at end of message, hands full blocks on
module sha256_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sha256_pkg::in_req_t  in_req_i,
  output logic                 blk_valid_o,
  input  logic                 blk_stall_i,
  output sha256_pkg::blk_cmd_t blk_cmd_o,
  output logic [511:0]         blk_data_o
);

  logic [511:0] buf_q, buf_d;
  logic [63:0]  cnt_q, cnt_d;
  logic         ov_q, ov_d;      // output block register full
  logic         fin_q, fin_d;
  logic [511:0] ob_q, ob_d;
  logic         pend_q, pend_d;  // second padding block still to send
  logic [63:0]  bits_q, bits_d;
  logic         lead_q, lead_d;  // second padding block opens with the pad marker

  logic         take;
  logic         slot_free;
  logic [511:0] wb;
  logic [5:0]   pos;
  logic [63:0]  cnt_b;
  logic [511:0] pad;
  logic [511:0] lenblk;

  assign slot_free  = !ov_q || !blk_stall_i;
  assign in_stall_o = !slot_free || pend_q;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    wb    = buf_q;
    cnt_b = cnt_q;
    if (in_req_i.byte_valid) begin
      wb[511 - 8*cnt_q[5:0] -: 8] = in_req_i.data_byte;
      cnt_b = cnt_q + 64'd1;
    end
    pos = cnt_b[5:0];
    pad = wb;
    for (int i = 0; i < 64; i++) begin
      if (i[5:0] == pos) pad[511 - 8*i -: 8] = 8'h80;
      else if (i[5:0] > pos) pad[511 - 8*i -: 8] = 8'h00;
    end
    lenblk = {448'd0, cnt_b[60:0], 3'b000};
  end

  always_comb begin
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    ov_d   = ov_q && blk_stall_i;
    ob_d   = ob_q;
    fin_d  = fin_q;
    pend_d = pend_q;
    bits_d = bits_q;
    lead_d = lead_q;
    if (pend_q && slot_free) begin
      ov_d   = 1'b1;
      fin_d  = 1'b1;
      ob_d   = {(lead_q ? 8'h80 : 8'h00), 440'd0, bits_q};
      pend_d = 1'b0;
    end else if (take) begin
      buf_d = wb;
      cnt_d = cnt_b;
      if (in_req_i.end_of_message) begin
        ov_d  = 1'b1;
        cnt_d = '0;
        if (pos > 6'd55) begin
          ob_d   = pad;
          fin_d  = 1'b0;
          pend_d = 1'b1;
          lead_d = 1'b0;
          bits_d = {cnt_b[60:0], 3'b000};
        end else if (in_req_i.byte_valid && pos == 6'd0) begin
          // last byte filled the block, padding needs a block of its own
          ob_d   = wb;
          fin_d  = 1'b0;
          pend_d = 1'b1;
          lead_d = 1'b1;
          bits_d = {cnt_b[60:0], 3'b000};
        end else begin
          ob_d  = {pad[511:64], 64'd0} | lenblk;
          fin_d = 1'b1;
        end
      end else if (in_req_i.byte_valid && pos == 6'd0) begin
        ov_d  = 1'b1;
        ob_d  = wb;
        fin_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ov_q   <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    ob_q   <= ob_d;
    fin_q  <= fin_d;
    bits_q <= bits_d;
    lead_q <= lead_d;
  end

  assign blk_valid_o         = ov_q;
  assign blk_cmd_o.final_blk = fin_q;
  assign blk_data_o          = ob_q;

  a_pend_ov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ov_q) else $error("pending pad block without first block");
  a_no_take_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !take) else $error("item taken while pad block pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && blk_stall_i |=> ov_q) else $error("block dropped while stalled");

endmodule

@@ rtl/core/sha256_engine.sv @@
// one round per cycle compression with a 16-word schedule window
module sha256_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 blk_valid_i,
  output logic                 blk_stall_o,
  input  sha256_pkg::blk_cmd_t blk_cmd_i,
  input  logic [511:0]         blk_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sha256_pkg::out_req_t out_req_o
);

  sha256_pkg::eng_state_e st_q, st_d;
  logic [255:0] h_q, h_d;
  logic [255:0] v_q, v_d;
  logic [511:0] w_q, w_d;
  logic [5:0]   rnd_q, rnd_d;
  logic         fin_q, fin_d;
  logic [2:0]   idx_q, idx_d;
  logic         take;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] a, b, c, d, e, f, g, h, t1, t2, w0, wn, x, y;

  always_comb begin
    {a, b, c, d, e, f, g, h} = v_q;
    w0 = w_q[511:480];
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + sha256_pkg::round_k(rnd_q) + w0;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    x  = w_q[479:448];
    y  = w_q[63:32];
    wn = (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10)) + w_q[223:192]
         + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w0;
  end

  always_comb begin
    st_d = st_q;
    take = 1'b0;
    case (st_q)
      sha256_pkg::EngIdle:  if (blk_valid_i) begin
        st_d = sha256_pkg::EngRound;
        take = 1'b1;
      end
      sha256_pkg::EngRound: if (rnd_q == 6'(sha256_pkg::NumRounds - 1)) st_d = sha256_pkg::EngAdd;
      sha256_pkg::EngAdd:   st_d = fin_q ? sha256_pkg::EngEmit : sha256_pkg::EngIdle;
      sha256_pkg::EngEmit:  if (!out_stall_i && idx_q == 3'd7) st_d = sha256_pkg::EngIdle;
      default:              st_d = sha256_pkg::EngIdle;
    endcase
  end

  always_comb begin
    h_d   = h_q;
    v_d   = v_q;
    w_d   = w_q;
    rnd_d = rnd_q;
    fin_d = fin_q;
    idx_d = idx_q;
    case (st_q)
      sha256_pkg::EngIdle: begin
        v_d   = h_q;
        w_d   = blk_data_i;
        rnd_d = '0;
        fin_d = blk_cmd_i.final_blk;
        idx_d = '0;
      end
      sha256_pkg::EngRound: begin
        v_d   = {t1 + t2, a, b, c, d + t1, e, f, g};
        w_d   = {w_q[479:0], wn};
        rnd_d = rnd_q + 6'd1;
      end
      sha256_pkg::EngAdd: begin
        for (int i = 0; i < 8; i++) h_d[32*i +: 32] = h_q[32*i +: 32] + v_q[32*i +: 32];
      end
      sha256_pkg::EngEmit: if (!out_stall_i) begin
        idx_d = idx_q + 3'd1;
        if (idx_q == 3'd7) h_d = sha256_pkg::init_hash();
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= sha256_pkg::EngIdle;
      h_q   <= sha256_pkg::init_hash();
      rnd_q <= '0;
      idx_q <= '0;
      fin_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      h_q   <= h_d;
      rnd_q <= rnd_d;
      idx_q <= idx_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

  assign blk_stall_o           = !take;
  assign out_valid_o           = (st_q == sha256_pkg::EngEmit);
  assign out_req_o.digest_word = h_q[255 - 32*idx_q -: 32];
  assign out_req_o.word_index  = idx_q;
  assign out_req_o.last_word   = (idx_q == 3'd7);

  a_emit_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fin_q) else $error("digest emitted for non-final block");
  a_rnd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> rnd_q == 6'd0) else $error("round counter not cleared");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> st_q == sha256_pkg::EngIdle) else $error("block taken while busy");

endmodule

@@ rtl/core/sha256_stream_hasher_unit.sv @@
// SHA-256 over a byte stream, one request per cycle at most. A request is
// taken in the cycle it is offered unless a finished block waits for the
// compression engine or a second padding block is still to be handed on; the
// engine takes no new block until done with the last (load, rounds, state
// add), so sustained throughput is set by the single shared round unit. At end
// of message one or two padded blocks follow, and the eight digest words leave
// one per cycle unless stalled, word zero first; then the chaining state re-arms.
module sha256_stream_hasher_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sha256_pkg::in_req_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sha256_pkg::out_req_t out_req_o
);

  logic                 blk_valid;
  logic                 blk_stall;
  sha256_pkg::blk_cmd_t blk_cmd;
  logic [511:0]         blk_data;

  sha256_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .blk_valid_o (blk_valid),
    .blk_stall_i (blk_stall),
    .blk_cmd_o   (blk_cmd),
    .blk_data_o  (blk_data)
  );

  sha256_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (blk_valid),
    .blk_stall_o (blk_stall),
    .blk_cmd_i   (blk_cmd),
    .blk_data_i  (blk_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

@@ verif/tb_sha256_stream_hasher_unit.sv @@
module tb_sha256_stream_hasher_unit;

  localparam int unsigned LimitCycles = 1000000;
  localparam int unsigned DrainCycles = 200;

  // digest bookkeeping: software sha-256 plus a queue of words still owed
  class digest_board;
    logic [31:0] chain[8];
    logic [7:0]  blk[64];
    logic [63:0] nbytes;
    sha256_pkg::out_req_t owed[$];
    int          fails;
    int          digests;

    function void rearm();
      logic [255:0] iv;
      iv = init_hash_value();
      for (int i = 0; i < 8; i++) chain[i] = iv[255 - 32*i -: 32];
      nbytes = '0;
    endfunction

    static function logic [255:0] init_hash_value();
      return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    endfunction

    static function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    static function logic [31:0] kconst(int r);
      logic [31:0] kt[64];
      kt = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return kt[r];
    endfunction

    function void compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] s0, s1, t1, t2;
      for (int r = 0; r < 16; r++)
        w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      for (int r = 16; r < 64; r++) begin
        s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
        s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
        w[r] = s1 + w[r-7] + s0 + w[r-16];
      end
      v = chain;
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(r) + w[r];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int i = 7; i > 0; i--) v[i] = v[i-1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function new();
      rearm();
      fails = 0;
      digests = 0;
    endfunction

    function void note_request(sha256_pkg::in_req_t rq);
      int unsigned pos;
      logic [63:0] bits;
      sha256_pkg::out_req_t w;
      if (rq.byte_valid) begin
        blk[nbytes[5:0]] = rq.data_byte;
        nbytes++;
        if (nbytes[5:0] == 0) compress();
      end
      if (!rq.end_of_message) return;
      pos = nbytes[5:0];
      bits = nbytes << 3;
      blk[pos++] = 8'h80;
      if (pos > 56) begin
        for (int i = pos; i < 64; i++) blk[i] = 8'h00;
        compress();
        pos = 0;
      end
      for (int i = pos; i < 56; i++) blk[i] = 8'h00;
      for (int k = 0; k < 8; k++) blk[56+k] = bits[63 - 8*k -: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
        w.digest_word = chain[k];
        w.word_index = k[2:0];
        w.last_word = (k == 7);
        owed.push_back(w);
      end
      digests++;
      rearm();
    endfunction

    function void check_word(sha256_pkg::out_req_t got);
      sha256_pkg::out_req_t exp_w;
      if (owed.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected digest word %h", got);
        return;
      end
      exp_w = owed.pop_front();
      if (got.digest_word !== exp_w.digest_word || got.word_index !== exp_w.word_index ||
          got.last_word !== exp_w.last_word) begin
        fails++;
        if (fails <= 10)
          $display("digest mismatch: exp word %h idx %0d last %b, got %h idx %0d last %b",
                   exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                   got.digest_word, got.word_index, got.last_word);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  sha256_pkg::in_req_t  in_req_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  sha256_pkg::out_req_t out_req_o;

  digest_board board = new();
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;
  bit          hold_rx = 1'b0;
  int          sent = 0;

  sha256_stream_hasher_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_req_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("timeout with %0d digest words outstanding", board.owed.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: sample and check, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_word(out_req_o);
    if (hold_rx) out_stall_i <= 1'b1;
    else out_stall_i <= !calm && ($urandom_range(99) < 16);
  end

  // offer one request and wait until it is taken; valid stays up for the next one
  task automatic push_request(logic [7:0] b, logic bv, logic eom);
    sha256_pkg::in_req_t rq;
    rq.data_byte = b;
    rq.byte_valid = bv;
    rq.end_of_message = eom;
    while (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      in_req_i <= 10'($urandom_range(1023));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= rq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(rq);
    sent++;
  endtask

  task automatic push_message(int len, int mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom_range(255));
      endcase
      push_request(b, 1'b1, i == len - 1);
    end
    if (len == 0) push_request(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic wait_owed_empty();
    while (board.owed.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int len;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    calm = 1'b1;
    // empty message, single bytes at the extremes, idle items
    push_message(0, 0);
    push_request(8'h00, 1'b1, 1'b1);
    push_request(8'hff, 1'b1, 1'b1);
    push_request(8'hab, 1'b0, 1'b0);
    push_request(8'h5a, 1'b1, 1'b0);
    push_request(8'h00, 1'b0, 1'b1);
    // end flag on the byte that fills a block
    push_message(64, 2);
    calm = 1'b0;
    // padding edges: 55 fits, 56 needs an extra block
    push_message(55, 1);
    push_message(56, 0);
    // receiver holds off for a long stretch while requests keep coming
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      begin
        push_message(3, 2);
        push_message(2, 2);
        push_message(20, 2);
        in_valid_i <= 1'b0;
      end
    join
    wait_owed_empty();
    calm = 1'b1;
    push_message(1, 2);
    calm = 1'b0;
    while (sent < 230 || board.digests < 16) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(8);
      if ($urandom_range(9) == 0)
        push_request(8'($urandom_range(255)), 1'b0, 1'b0);
      push_message(len, 2);
    end
    in_valid_i <= 1'b0;
    wait_owed_empty();
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d requests sent, %0d digests covering empty, padding-edge and stalled messages",
             sent, board.digests);
    if (board.fails == 0 && board.owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", board.fails);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
